// File: rtl/iatv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iatv_pkg;

   typedef enum logic [1:0] {
      VERDICT_IPV4 = 2'd0,
      VERDICT_IPV6 = 2'd1,
      VERDICT_NONE = 2'd2
   } verdict_type;

   localparam int DOT_W   = 3;
   localparam int COLON_W = 4;
   localparam int LEN_W   = 3;
   localparam int NUM_W   = 10;
   localparam int PROD_W  = 14;

   localparam logic [DOT_W-1:0]   DOT_MAX   = 3'd7;
   localparam logic [COLON_W-1:0] COLON_MAX = 4'd15;
   localparam logic [LEN_W-1:0]   LEN_MAX   = 3'd7;
   localparam logic [NUM_W-1:0]   NUM_MAX   = 10'd1023;

   localparam logic [DOT_W-1:0]   V4_DOTS     = 3'd3;
   localparam logic [COLON_W-1:0] V6_COLONS   = 4'd7;
   localparam logic [LEN_W-1:0]   V4_LEN_MAX  = 3'd3;
   localparam logic [LEN_W-1:0]   V6_LEN_MAX  = 3'd4;
   localparam logic [NUM_W-1:0]   V4_NUM_MAX  = 10'd255;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

endpackage : iatv_pkg

`default_nettype wire

// File: rtl/ip_address_text_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Address text validator: classify a string as IPv4, IPv6 or neither.
// Input stream (req_): one ASCII character per word in req_tdata, req_tlast
// on the last character of a string. Every character is checked as it
// arrives; fields are judged when a dot, a colon or the end closes them.
// Result stream (rsp_): one word per string, the verdict in rsp_tdata
// (0 IPv4, 1 IPv6, 2 neither), nothing for characters without req_tlast.
// Throughput: one character per cycle while the skid entry is empty. The
// verdict is registered, via the skid entry if the output stalls; the per-character
// update is one shallow pass through the counter and flag registers.
// Stall: a verdict register and one skid entry hold results; characters keep
// flowing while one verdict waits, and req_tready drops only when both
// entries are full. Reset clears all counts, flags and pending verdicts.
// After each last character all per-string state returns to its reset values.
module ip_address_text_validator_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // is_final
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [1:0] verdict, [7:2] zero
);
   import iatv_pkg::*;

   logic [DOT_W-1:0]   dot_count_ff, dot_count_in;
   logic [COLON_W-1:0] colon_count_ff, colon_count_in;
   logic [LEN_W-1:0]   field_length_ff, field_length_in;
   logic [NUM_W-1:0]   field_number_ff, field_number_in;
   logic               starts_zero_ff, starts_zero_in;
   logic               has_letter_ff, has_letter_in;
   logic               bad_char_ff, bad_char_in;
   logic               v4_failed_ff, v4_failed_in;
   logic               v6_failed_ff, v6_failed_in;

   logic               out_valid_ff, out_valid_in;
   verdict_type        out_verdict_ff, out_verdict_in;
   logic               skid_valid_ff, skid_valid_in;
   verdict_type        skid_verdict_ff, skid_verdict_in;

   logic               req_fire;
   logic               push;
   logic               is_digit, is_letter, is_dot, is_colon, is_delim;
   logic [PROD_W-1:0]  num_product;
   logic [3:0]         digit;
   logic [LEN_W-1:0]   post_length;
   logic [NUM_W-1:0]   post_number;
   logic               post_zero, post_letter;
   verdict_type        verdict;

   function automatic logic v4_field_ok(input logic [LEN_W-1:0] len,
                                        input logic [NUM_W-1:0] num,
                                        input logic             zero,
                                        input logic             letter);
      v4_field_ok = (len != '0) && (len <= V4_LEN_MAX) && !letter &&
                    !((len > 3'd1) && zero) && (num <= V4_NUM_MAX);
   endfunction

   function automatic logic v6_field_ok(input logic [LEN_W-1:0] len);
      v6_field_ok = (len != '0) && (len <= V6_LEN_MAX);
   endfunction

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign push       = req_fire && req_tlast;

   assign is_digit  = (req_tdata >= CHAR_0) && (req_tdata <= CHAR_9);
   assign is_letter = ((req_tdata >= CHAR_LC_A) && (req_tdata <= CHAR_LC_F)) ||
                      ((req_tdata >= CHAR_UC_A) && (req_tdata <= CHAR_UC_F));
   assign is_dot    = (req_tdata == CHAR_DOT);
   assign is_colon  = (req_tdata == CHAR_COLON);
   assign is_delim  = is_dot || is_colon;
   assign digit     = 4'(req_tdata - CHAR_0);

   // value * 10 + digit, as two shifts and two adds
   assign num_product = {1'b0, field_number_ff, 3'b000} +
                        {3'b000, field_number_ff, 1'b0} +
                        {10'd0, digit};

   // field contents after this character (a delimiter opens a fresh field)
   always_comb begin
      post_length = field_length_ff;
      post_number = field_number_ff;
      post_zero   = starts_zero_ff;
      post_letter = has_letter_ff;
      if (is_digit || is_letter) begin
         if ((field_length_ff == '0) && (req_tdata == CHAR_0)) begin
            post_zero = 1'b1;
         end
         if (is_letter) begin
            post_letter = 1'b1;
         end else begin
            post_number = (num_product > PROD_W'(NUM_MAX)) ? NUM_MAX
                                                            : num_product[NUM_W-1:0];
         end
         if (field_length_ff < LEN_MAX) begin
            post_length = field_length_ff + 3'd1;
         end
      end else if (is_delim) begin
         post_length = '0;
         post_number = '0;
         post_zero   = 1'b0;
         post_letter = 1'b0;
      end
   end

   always_comb begin
      dot_count_in    = dot_count_ff;
      colon_count_in  = colon_count_ff;
      bad_char_in     = bad_char_ff || !(is_digit || is_letter || is_delim);
      v4_failed_in    = v4_failed_ff;
      v6_failed_in    = v6_failed_ff;
      field_length_in = post_length;
      field_number_in = post_number;
      starts_zero_in  = post_zero;
      has_letter_in   = post_letter;
      if (is_dot && (dot_count_ff < DOT_MAX)) begin
         dot_count_in = dot_count_ff + 3'd1;
      end
      if (is_colon && (colon_count_ff < COLON_MAX)) begin
         colon_count_in = colon_count_ff + 4'd1;
      end
      // close the field that the delimiter ends
      if (is_delim) begin
         v4_failed_in = v4_failed_in ||
            !v4_field_ok(field_length_ff, field_number_ff, starts_zero_ff, has_letter_ff);
         v6_failed_in = v6_failed_in || !v6_field_ok(field_length_ff);
      end
      // close the last field at the end of the string
      if (req_tlast) begin
         v4_failed_in = v4_failed_in ||
            !v4_field_ok(post_length, post_number, post_zero, post_letter);
         v6_failed_in = v6_failed_in || !v6_field_ok(post_length);
      end
   end

   always_comb begin
      verdict = VERDICT_NONE;
      if (!bad_char_in && !((dot_count_in != '0) && (colon_count_in != '0))) begin
         if ((dot_count_in == V4_DOTS) && !v4_failed_in) begin
            verdict = VERDICT_IPV4;
         end else if ((colon_count_in == V6_COLONS) && !v6_failed_in) begin
            verdict = VERDICT_IPV6;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         dot_count_ff    <= '0;
         colon_count_ff  <= '0;
         field_length_ff <= '0;
         field_number_ff <= '0;
         starts_zero_ff  <= 1'b0;
         has_letter_ff   <= 1'b0;
         bad_char_ff     <= 1'b0;
         v4_failed_ff    <= 1'b0;
         v6_failed_ff    <= 1'b0;
      end else if (req_fire) begin
         dot_count_ff    <= dot_count_in;
         colon_count_ff  <= colon_count_in;
         field_length_ff <= field_length_in;
         field_number_ff <= field_number_in;
         starts_zero_ff  <= starts_zero_in;
         has_letter_ff   <= has_letter_in;
         bad_char_ff     <= bad_char_in;
         v4_failed_ff    <= v4_failed_in;
         v6_failed_ff    <= v6_failed_in;
      end
   end

   // verdict register with one skid entry behind it
   always_comb begin
      out_valid_in    = out_valid_ff;
      out_verdict_in  = out_verdict_ff;
      skid_valid_in   = skid_valid_ff;
      skid_verdict_in = skid_verdict_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in   = 1'b1;
            out_verdict_in = skid_verdict_ff;
            skid_valid_in  = 1'b0;
         end else if (push) begin
            out_valid_in   = 1'b1;
            out_verdict_in = verdict;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_valid_in   = 1'b1;
         skid_verdict_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_verdict_ff  <= out_verdict_in;
      skid_verdict_ff <= skid_verdict_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_verdict_ff};

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while verdict register empty");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      push |=> (dot_count_ff == '0) && (colon_count_ff == '0) &&
               (field_length_ff == '0) && !bad_char_ff)
      else $error("string state not cleared after last character");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_verdict_ff == VERDICT_IPV4 ||
                        out_verdict_ff == VERDICT_IPV6 ||
                        out_verdict_ff == VERDICT_NONE))
      else $error("verdict register holds an unused code");

   a_no_verdict_lost: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("verdict dropped while output stalled");

endmodule : ip_address_text_validator_unit

`default_nettype wire

// File: tb/sv/ip_address_text_validator_unit_tb.sv
`timescale 1ns / 1ps

module ip_address_text_validator_unit_tb;
   import iatv_pkg::*;

   typedef logic [7:0] char_type;

   // Running copy of the per-string counters and flags; one verdict per last char.
   class address_verdict_check;
      verdict_type pending_verdicts[$];
      int failures;
      bit [DOT_W-1:0] dots;
      bit [COLON_W-1:0] colons;
      bit [LEN_W-1:0] len;
      bit [NUM_W-1:0] num;
      bit zero_lead, letter, bad_char, v4_broken, v6_broken;

      function void close_field();
         bit v4_ok, v6_ok;
         v4_ok = len >= 1 && len <= V4_LEN_MAX && !letter && !(len > 1 && zero_lead) &&
                 num <= V4_NUM_MAX;
         v6_ok = len >= 1 && len <= V6_LEN_MAX;
         if (!v4_ok) v4_broken = 1'b1;
         if (!v6_ok) v6_broken = 1'b1;
         len = '0;
         num = '0;
         zero_lead = 1'b0;
         letter = 1'b0;
      endfunction

      function void take_char(char_type ch, bit last);
         bit is_digit, is_letter;
         int prod;
         verdict_type v;
         is_digit = ch >= CHAR_0 && ch <= CHAR_9;
         is_letter = (ch >= CHAR_LC_A && ch <= CHAR_LC_F) ||
                     (ch >= CHAR_UC_A && ch <= CHAR_UC_F);
         if (is_digit || is_letter) begin
            if (len == 0 && ch == CHAR_0) zero_lead = 1'b1;
            if (is_letter) begin
               letter = 1'b1;
            end else begin
               prod = int'(num) * 10 + int'(ch - CHAR_0);
               num = (prod > int'(NUM_MAX)) ? NUM_MAX : prod[NUM_W-1:0];
            end
            if (len < LEN_MAX) len++;
         end else if (ch == CHAR_DOT) begin
            if (dots < DOT_MAX) dots++;
            close_field();
         end else if (ch == CHAR_COLON) begin
            if (colons < COLON_MAX) colons++;
            close_field();
         end else begin
            bad_char = 1'b1;
         end
         if (!last) return;
         close_field();
         v = VERDICT_NONE;
         if (!bad_char && !(dots != 0 && colons != 0)) begin
            if (dots == V4_DOTS && !v4_broken) v = VERDICT_IPV4;
            else if (colons == V6_COLONS && !v6_broken) v = VERDICT_IPV6;
         end
         pending_verdicts.insert(pending_verdicts.size(), v);
         dots = '0;
         colons = '0;
         bad_char = 1'b0;
         v4_broken = 1'b0;
         v6_broken = 1'b0;
      endfunction

      function void check_word(logic [7:0] word);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("verdict: expected none, got %0d", word[1:0]);
            failures++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (word[1:0] !== want) begin
            $error("verdict: expected %0d, got %0d", want, word[1:0]);
            failures++;
         end
         if (word[7:2] !== 6'd0) begin
            $error("pad: expected 0, got %0d", word[7:2]);
            failures++;
         end
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   address_verdict_check board = new();
   bit calm;
   int chars_sent;

   ip_address_text_validator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b0;
      #1 clock = 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      rsp_tready <= calm || ($urandom_range(99) >= 28);
   end

   function automatic char_type soup_char();
      string set;
      set = "0123456789abcdefABCDEF.:";
      if ($urandom_range(15) == 0) return char_type'($urandom_range(255));
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function automatic char_type hex_char();
      string set;
      set = "0123456789abcdefABCDEF";
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function automatic void push_text(ref char_type text[$], input string s);
      for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
   endfunction

   function automatic void build_v4(ref char_type text[$]);
      int pick, value;
      for (int f = 0; f < 4; f++) begin
         if (f > 0) text.insert(text.size(), CHAR_DOT);
         pick = $urandom_range(99);
         if (pick < 10) value = 0;
         else if (pick < 20) value = 255;
         else if (pick < 25) value = $urandom_range(256, 999);
         else value = $urandom_range(255);
         push_text(text, $sformatf("%0d", value));
      end
   endfunction

   function automatic void build_v6(ref char_type text[$]);
      int digits;
      for (int f = 0; f < 8; f++) begin
         if (f > 0) text.insert(text.size(), CHAR_COLON);
         digits = $urandom_range(1, 4);
         for (int k = 0; k < digits; k++) text.insert(text.size(), hex_char());
      end
   endfunction

   // Alter a well-formed address in one spot; the result may still be valid.
   function automatic void mutate(ref char_type text[$]);
      int pos;
      pos = $urandom_range(text.size() - 1);
      case ($urandom_range(6))
         0: text[pos] = char_type'($urandom_range(255));
         1: text[pos] = $urandom_range(1) ? CHAR_DOT : CHAR_COLON;
         2: if (text.size() > 1) text.delete(pos);
         3: text.insert(pos, soup_char());
         4: text.insert(pos, CHAR_0);
         5: text.insert(text.size(), $urandom_range(1) ? CHAR_DOT : CHAR_COLON);
         default: text.insert(0, $urandom_range(1) ? CHAR_DOT : CHAR_COLON);
      endcase
   endfunction

   task automatic send_char(input char_type ch, input bit last);
      while (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_char(ch, last);
   endtask

   task automatic send_string(input char_type text[$]);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
      chars_sent += text.size();
   endtask

   initial begin
      char_type text[$];
      int idx, pick, count;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      text = {};
      push_text(text, "1.0.255.9");
      send_string(text);
      text = {};
      push_text(text, "Af:");
      send_string(text);
      text = {CHAR_DOT};
      send_string(text);
      text = {8'h00};
      send_string(text);
      text = {8'hFF};
      send_string(text);
      text = {};
      push_text(text, "1.2:3");
      send_string(text);

      // hold the sender until every verdict is back
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);

      idx = 0;
      chars_sent = 0;
      while (chars_sent < 1200) begin
         calm = idx >= 15 && idx < 40;
         text = {};
         pick = $urandom_range(99);
         if (pick < 35) begin
            build_v4(text);
         end else if (pick < 60) begin
            build_v6(text);
         end else if (pick < 82) begin
            if ($urandom_range(1)) build_v4(text);
            else build_v6(text);
            mutate(text);
         end else if (pick < 94) begin
            count = $urandom_range(1, 40);
            repeat (count) text.insert(text.size(), soup_char());
         end else begin
            count = $urandom_range(1, 8);
            repeat (count) text.insert(text.size(), char_type'($urandom_range(255)));
         end
         send_string(text);
         idx++;
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (8) @(posedge clock);
      if (board.failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
